// ----- rtl/imuc_pkg.sv -----
// imuc_pkg: shared codes, constants and a scale function for the imu scale and bias calibration block
// no dependencies; imported by imuc_div and imu_sample_scale_and_bias_calibration
`default_nettype none

package imuc_pkg;

   // fraction bits of the stored offsets
   localparam int OFB = 8;

   localparam int RAW_W   = 16;
   localparam int OFS_W   = 25;
   localparam int SUM_W   = 33;
   localparam int CNT16_W = 16;
   localparam int MEAS_W  = 24;
   localparam int TEMP_W  = 17;
   localparam int ST_W    = 3;
   localparam int OP_W    = 2;
   localparam int FS_W    = 2;

   localparam int N_AXES = 6;
   localparam int N_MEAS = 7;
   localparam int IDX_W  = 3;

   // shared multiplier operands
   localparam int V_W    = ((RAW_W + OFB > OFS_W) ? RAW_W + OFB : OFS_W) + 1;
   localparam int B_W    = 23;
   localparam int PROD_W = V_W + B_W;
   localparam int SHIFT  = 16 + OFB;
   localparam int ADJ_W  = 32;
   localparam int ACC_EXP = 18;

   // divider for the offset means
   localparam int DIV_W = SUM_W - 1 + OFB;
   localparam int DEN_W = CNT16_W;
   localparam int DCNT_W = $clog2(DIV_W);

   // stream widths
   localparam int REQ_DATA_W = 7 * RAW_W;
   localparam int REQ_USER_W = OP_W + 1;
   localparam int RSP_DATA_W = ((N_AXES * MEAS_W + TEMP_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 1 + ST_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_FS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_FS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_N    = 2'd2;

   localparam logic [OP_W-1:0] OP_MEASURE    = 2'd0;
   localparam logic [OP_W-1:0] OP_CAL_START  = 2'd1;
   localparam logic [OP_W-1:0] OP_CAL_SAMPLE = 2'd2;
   localparam logic [OP_W-1:0] OP_CAL_RESET  = 2'd3;

   localparam logic [ST_W-1:0] ST_OK          = 3'd0;
   localparam logic [ST_W-1:0] ST_INVALID     = 3'd1;
   localparam logic [ST_W-1:0] ST_CALIBRATING = 3'd2;
   localparam logic [ST_W-1:0] ST_CAL_DONE    = 3'd3;
   localparam logic [ST_W-1:0] ST_CAL_FAILED  = 3'd4;
   localparam logic [ST_W-1:0] ST_NOT_CAL     = 3'd5;

   localparam logic [CNT16_W-1:0] CAL_N_RESET = 16'd100;

   localparam logic [B_W-1:0] TEMP_RECIP = 23'd49345;
   localparam int ONE_G    = 65536;
   localparam int TEMP_OFS = 9352;

   localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};

   // gyro sensitivity reciprocals, q.24
   function automatic logic [B_W-1:0] gyro_recip(input logic [FS_W-1:0] fs);
      logic [B_W-1:0] r;
      unique case (fs)
         2'd0: r = 23'd128070;
         2'd1: r = 23'd256141;
         2'd2: r = 23'd511500;
         2'd3: r = 23'd1023001;
         default: r = 23'd128070;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/imuc_div.sv -----
// imuc_div: restoring unsigned divider, one quotient bit per cycle
// depends on imuc_pkg for operand widths
`default_nettype none

module imuc_div
   import imuc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [DIV_W-1:0]      quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    shifted;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/imu_sample_scale_and_bias_calibration.sv -----
// imu_sample_scale_and_bias_calibration: six-axis sample scaling with bias calibration
// depends on imuc_pkg and imuc_div
// measure: one shared 26x23 multiplier, a multiply (S_MUL) and a round (S_RND) step per field for 7 fields
// calibration sample: valid ones are summed per axis (S_ACC) then checked (S_CHK), invalid ones only checked
// finishing sample: the six offset means, with 8 fraction bits, are then divided in turn on the serial divider
// other ops: straight to the output step; output register lets the next transfer in while a result waits
// reset is synchronous, active high: config to defaults, offsets/sums/counts cleared
`default_nettype none

module imu_sample_scale_and_bias_calibration
   import imuc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_temperature
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op, sample_ok
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // accel_x_g, accel_y_g, accel_z_g, rate_x_dps, rate_y_dps, rate_z_dps, temperature_c, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // is_calibrated, status
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_RND   = 4'd2;
   localparam logic [3:0] S_ACC   = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_DIVGO = 4'd5;
   localparam logic [3:0] S_DIVW  = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   localparam logic [IDX_W-1:0] IDX_LAST_AXIS = IDX_W'(N_AXES - 1);
   localparam logic [IDX_W-1:0] IDX_TEMP      = IDX_W'(N_MEAS - 1);
   localparam logic [IDX_W-1:0] IDX_ACC_Z     = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_GYRO_X    = IDX_W'(3);

   logic [3:0]          state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [FS_W-1:0]     afs_ff, afs_in;
   logic [FS_W-1:0]     gfs_ff, gfs_in;
   logic [CNT16_W-1:0]  cal_n_ff, cal_n_in;
   logic [CNT16_W-1:0]  valid_ff, valid_in;
   logic [CNT16_W-1:0]  attempt_ff, attempt_in;
   logic                calibrating_ff, calibrating_in;
   logic                calibrated_ff, calibrated_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] sums_ff [N_AXES];
   logic signed [SUM_W-1:0] sums_in [N_AXES];
   logic signed [OFS_W-1:0] ofs_ff [N_AXES];
   logic signed [OFS_W-1:0] ofs_in [N_AXES];

   logic signed [RAW_W-1:0]  raw_ff [N_MEAS];
   logic signed [RAW_W-1:0]  raw_in [N_MEAS];
   logic signed [MEAS_W-1:0] meas_ff [N_MEAS];
   logic signed [MEAS_W-1:0] meas_in [N_MEAS];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [ST_W-1:0]          status_ff, status_in;
   logic                     neg_ff, neg_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]    rsp_user_ff, rsp_user_in;

   logic signed [V_W-1:0]    v_sel;
   logic signed [OFS_W-1:0]  ofs_sel;
   logic signed [B_W-1:0]    b_sel;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [ADJ_W-1:0]  adj;
   logic signed [SUM_W-1:0]  sum_sel;
   logic [SUM_W-1:0]         mag;
   logic                     div_start;
   logic [DIV_W-1:0]         div_dividend;
   logic                     div_done;
   logic [DIV_W-1:0]         div_q;

   imuc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (valid_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // saturate to 24 bits, or 17 for temperature
   function automatic logic signed [MEAS_W-1:0] sat_meas(input logic signed [ADJ_W-1:0] x,
                                                         input logic temp);
      logic signed [ADJ_W-1:0] hi;
      logic signed [ADJ_W-1:0] lo;
      hi = temp ? ADJ_W'((1 << (TEMP_W - 1)) - 1) : ADJ_W'((1 << (MEAS_W - 1)) - 1);
      lo = -hi - 1;
      if (x > hi) begin
         return MEAS_W'(hi);
      end else if (x < lo) begin
         return MEAS_W'(lo);
      end
      return MEAS_W'(x);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // shared multiplier operands
   always_comb begin
      ofs_sel = (calibrated_ff && idx_ff <= IDX_LAST_AXIS) ? ofs_ff[idx_ff] : '0;
      v_sel   = (V_W'(raw_ff[idx_ff]) <<< OFB) - V_W'(ofs_sel);
      if (idx_ff < IDX_GYRO_X) begin
         b_sel = B_W'(1) << (ACC_EXP + int'(afs_ff));
      end else if (idx_ff <= IDX_LAST_AXIS) begin
         b_sel = gyro_recip(gfs_ff);
      end else begin
         b_sel = TEMP_RECIP;
      end
      prod_rnd = (prod_ff + (PROD_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
      adj      = ADJ_W'(prod_rnd);
      if (idx_ff == IDX_TEMP) begin
         adj = adj + ADJ_W'(TEMP_OFS);
      end else if (idx_ff == IDX_ACC_Z && calibrated_ff) begin
         adj = adj + ADJ_W'(ONE_G);
      end
      sum_sel      = sums_ff[idx_ff];
      mag          = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
      div_dividend = (DIV_W'(mag[SUM_W-2:0]) << OFB) + DIV_W'(valid_ff >> 1);
   end

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      afs_in         = afs_ff;
      gfs_in         = gfs_ff;
      cal_n_in       = cal_n_ff;
      valid_in       = valid_ff;
      attempt_in     = attempt_ff;
      calibrating_in = calibrating_ff;
      calibrated_in  = calibrated_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      sums_in        = sums_ff;
      ofs_in         = ofs_ff;
      raw_in         = raw_ff;
      meas_in        = meas_ff;
      prod_in        = prod_ff;
      status_in      = status_ff;
      neg_in         = neg_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      div_start      = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ACCEL_FS: afs_in   = csr_wdata[FS_W-1:0];
            CSR_GYRO_FS:  gfs_in   = csr_wdata[FS_W-1:0];
            CSR_CAL_N:    cal_n_in = csr_wdata[CNT16_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < N_MEAS; k++) begin
                  raw_in[k]  = req_tdata[k*RAW_W +: RAW_W];
                  meas_in[k] = '0;
               end
               idx_in   = '0;
               state_in = S_OUT;
               unique case (req_tuser[OP_W-1:0])
                  OP_MEASURE: begin
                     if (req_tuser[OP_W]) begin
                        status_in = ST_OK;
                        state_in  = S_MUL;
                     end else begin
                        status_in = ST_INVALID;
                     end
                  end
                  OP_CAL_START: begin
                     for (int k = 0; k < N_AXES; k++) begin
                        sums_in[k] = '0;
                        ofs_in[k]  = '0;
                     end
                     valid_in      = '0;
                     attempt_in    = '0;
                     calibrated_in = 1'b0;
                     if (cal_n_ff == '0) begin
                        calibrating_in = 1'b0;
                        status_in      = ST_CAL_FAILED;
                     end else begin
                        calibrating_in = 1'b1;
                        status_in      = ST_CALIBRATING;
                     end
                  end
                  OP_CAL_SAMPLE: begin
                     if (!calibrating_ff) begin
                        status_in = ST_NOT_CAL;
                     end else begin
                        attempt_in = attempt_ff + 1'b1;
                        if (req_tuser[OP_W]) begin
                           valid_in = valid_ff + 1'b1;
                           state_in = S_ACC;
                        end else begin
                           state_in = S_CHK;
                        end
                     end
                  end
                  OP_CAL_RESET: begin
                     for (int k = 0; k < N_AXES; k++) begin
                        sums_in[k] = '0;
                        ofs_in[k]  = '0;
                     end
                     valid_in       = '0;
                     attempt_in     = '0;
                     calibrated_in  = 1'b0;
                     calibrating_in = 1'b0;
                     status_in      = ST_OK;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL: begin
            prod_in  = v_sel * b_sel;
            state_in = S_RND;
         end
         S_RND: begin
            meas_in[idx_ff] = sat_meas(adj, idx_ff == IDX_TEMP);
            if (idx_ff == IDX_TEMP) begin
               state_in = S_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_ACC: begin
            sums_in[idx_ff] = sums_ff[idx_ff] + SUM_W'(raw_ff[idx_ff]);
            if (idx_ff == IDX_LAST_AXIS) begin
               state_in = S_CHK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CHK: begin
            if (attempt_ff >= cal_n_ff) begin
               calibrating_in = 1'b0;
               if (valid_ff == '0 || valid_ff < (cal_n_ff >> 1)) begin
                  status_in = ST_CAL_FAILED;
                  state_in  = S_OUT;
               end else begin
                  idx_in   = '0;
                  state_in = S_DIVGO;
               end
            end else begin
               status_in = ST_CALIBRATING;
               state_in  = S_OUT;
            end
         end
         S_DIVGO: begin
            div_start = 1'b1;
            neg_in    = sum_sel[SUM_W-1];
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               if (neg_ff) begin
                  ofs_in[idx_ff] = (div_q > DIV_W'(OFS_MAX) + 1'b1) ?
                                   -OFS_MAX - 1'b1 : -OFS_W'(div_q);
               end else begin
                  ofs_in[idx_ff] = (div_q > DIV_W'(OFS_MAX)) ? OFS_MAX : OFS_W'(div_q);
               end
               if (idx_ff == IDX_LAST_AXIS) begin
                  calibrated_in = 1'b1;
                  status_in     = ST_CAL_DONE;
                  state_in      = S_OUT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DIVGO;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = '0;
               for (int k = 0; k < N_AXES; k++) begin
                  rsp_data_in[k*MEAS_W +: MEAS_W] = meas_ff[k];
               end
               rsp_data_in[N_AXES*MEAS_W +: TEMP_W] = meas_ff[N_MEAS-1][TEMP_W-1:0];
               rsp_user_in  = {status_ff, calibrated_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= '0;
         afs_ff         <= '0;
         gfs_ff         <= '0;
         cal_n_ff       <= CAL_N_RESET;
         valid_ff       <= '0;
         attempt_ff     <= '0;
         calibrating_ff <= 1'b0;
         calibrated_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < N_AXES; k++) begin
            sums_ff[k] <= '0;
            ofs_ff[k]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         afs_ff         <= afs_in;
         gfs_ff         <= gfs_in;
         cal_n_ff       <= cal_n_in;
         valid_ff       <= valid_in;
         attempt_ff     <= attempt_in;
         calibrating_ff <= calibrating_in;
         calibrated_ff  <= calibrated_in;
         rsp_valid_ff   <= rsp_valid_in;
         sums_ff        <= sums_in;
         ofs_ff         <= ofs_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      meas_ff     <= meas_in;
      prod_ff     <= prod_in;
      status_ff   <= status_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for imu_sample_scale_and_bias_calibration
// a directed pass over scaling extremes and calibration outcomes, then randomized calibration and mixed-op traffic
// depends on imuc_pkg and the block's rtl; results are checked against an in-bench prediction
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import imuc_pkg::*;

   localparam int ITEM_TARGET   = 1150;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 200;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic                     cal_flag;
      logic [TEMP_W-1:0]        temp_c;
      logic [N_AXES*MEAS_W-1:0] motion;
   } imu_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predicted register and calibration state
   logic [FS_W-1:0]    accel_fs_m;
   logic [FS_W-1:0]    gyro_fs_m;
   logic [CNT16_W-1:0] cal_len_m;
   longint             axis_sum [N_AXES];
   longint             axis_ofs [N_AXES];
   int unsigned        valid_cnt;
   int unsigned        attempt_cnt;
   bit                 cal_running;
   bit                 cal_applied;
   longint             rate_recip [4] = '{128070, 256141, 511500, 1023001};

   imu_result_type pending_results [$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          quiet_cycles = 0;
   bit          fast_phase = 1'b0;
   logic [RAW_W-1:0] axis_bias [N_MEAS];
   int          noise_span = 0;
   string       meas_name [N_AXES] = '{"accel_x_g", "accel_y_g", "accel_z_g",
                                       "rate_x_dps", "rate_y_dps", "rate_z_dps"};

   imu_sample_scale_and_bias_calibration dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounds half up
   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // rounds half away from zero
   function automatic longint axis_mean(longint sum, longint count);
      longint mag;
      mag = (sum < 0) ? -sum : sum;
      mag = ((mag <<< OFB) + count / 2) / count;
      return saturate((sum < 0) ? -mag : mag, OFS_W);
   endfunction

   function automatic void clear_calibration();
      for (int i = 0; i < N_AXES; i++) begin
         axis_sum[i] = 0;
         axis_ofs[i] = 0;
      end
      valid_cnt = 0;
      attempt_cnt = 0;
      cal_applied = 1'b0;
   endfunction

   function automatic imu_result_type predict_imu_result(logic [OP_W-1:0] op, logic ok,
                                                         logic [REQ_DATA_W-1:0] raws);
      imu_result_type res;
      longint      raw [N_MEAS];
      longint      v;
      longint      r;
      longint      lim;
      res = '0;
      res.status = ST_OK;
      for (int i = 0; i < N_MEAS; i++) raw[i] = longint'($signed(raws[i*RAW_W +: RAW_W]));
      case (op)
         OP_MEASURE: begin
            if (!ok) begin
               res.status = ST_INVALID;
            end else begin
               for (int i = 0; i < N_AXES; i++) begin
                  v = raw[i] <<< OFB;
                  if (cal_applied) v = v - axis_ofs[i];
                  if (i < 3) begin
                     r = round_shift(v * (longint'(4) <<< accel_fs_m), OFB);
                     if (i == 2 && cal_applied) r = r + ONE_G;
                  end else begin
                     r = round_shift(v * rate_recip[gyro_fs_m], SHIFT);
                  end
                  lim = saturate(r, MEAS_W);
                  res.motion[i*MEAS_W +: MEAS_W] = lim[MEAS_W-1:0];
               end
               lim = saturate(round_shift(raw[6] * longint'(TEMP_RECIP), 16) + TEMP_OFS, TEMP_W);
               res.temp_c = lim[TEMP_W-1:0];
            end
         end
         OP_CAL_START: begin
            clear_calibration();
            cal_running = (cal_len_m != 0);
            res.status = cal_running ? ST_CALIBRATING : ST_CAL_FAILED;
         end
         OP_CAL_SAMPLE: begin
            if (!cal_running) begin
               res.status = ST_NOT_CAL;
            end else begin
               if (ok) begin
                  for (int i = 0; i < N_AXES; i++) axis_sum[i] = axis_sum[i] + raw[i];
                  valid_cnt = (valid_cnt + 1) & 16'hFFFF;
               end
               attempt_cnt = (attempt_cnt + 1) & 16'hFFFF;
               if (attempt_cnt >= cal_len_m) begin
                  cal_running = 1'b0;
                  if (valid_cnt == 0 || valid_cnt < cal_len_m / 2) begin
                     res.status = ST_CAL_FAILED;
                  end else begin
                     for (int i = 0; i < N_AXES; i++)
                        axis_ofs[i] = axis_mean(axis_sum[i], longint'(valid_cnt));
                     cal_applied = 1'b1;
                     res.status = ST_CAL_DONE;
                  end
               end else begin
                  res.status = ST_CALIBRATING;
               end
            end
         end
         OP_CAL_RESET: begin
            clear_calibration();
            cal_running = 1'b0;
            res.status = ST_OK;
         end
      endcase
      res.cal_flag = cal_applied;
      return res;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] any_sample();
      logic [REQ_DATA_W-1:0] s;
      for (int i = 0; i < N_MEAS; i++) s[i*RAW_W +: RAW_W] = RAW_W'($urandom);
      return s;
   endfunction

   // raw counts scattered around a per-axis level
   function automatic logic [REQ_DATA_W-1:0] biased_sample();
      logic [REQ_DATA_W-1:0] s;
      int                    off;
      for (int i = 0; i < N_MEAS; i++) begin
         off = int'($urandom_range(0, 2 * noise_span)) - noise_span;
         s[i*RAW_W +: RAW_W] = axis_bias[i] + off[RAW_W-1:0];
      end
      return s;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ACCEL_FS: accel_fs_m = value[FS_W-1:0];
         CSR_GYRO_FS:  gyro_fs_m = value[FS_W-1:0];
         CSR_CAL_N:    cal_len_m = value;
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic ok,
                            input logic [REQ_DATA_W-1:0] raws);
      int gap;
      gap = fast_phase ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pending_results.push_back(predict_imu_result(op, ok, raws));
      req_tvalid <= 1'b1;
      req_tdata  <= raws;
      req_tuser  <= {ok, op};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // hold off the sender until every result is back and the block has settled
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
      end
   endtask

   task automatic check_result();
      imu_result_type want;
      imu_result_type got;
      got.motion   = rsp_tdata[N_AXES*MEAS_W-1:0];
      got.temp_c   = rsp_tdata[N_AXES*MEAS_W +: TEMP_W];
      got.cal_flag = rsp_tuser[0];
      got.status   = rsp_tuser[1 +: ST_W];
      if (pending_results.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: rsp transfer expected none, got %h", $time, got);
      end else begin
         want = pending_results.pop_front();
         for (int i = 0; i < N_AXES; i++)
            report_field(meas_name[i], 32'(want.motion[i*MEAS_W +: MEAS_W]),
                         32'(got.motion[i*MEAS_W +: MEAS_W]));
         report_field("temperature_c", 32'(want.temp_c), 32'(got.temp_c));
         report_field("is_calibrated", 32'(want.cal_flag), 32'(got.cal_flag));
         report_field("status", 32'(want.status), 32'(got.status));
      end
   endtask

   initial begin : result_sink
      int stall;
      stall = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            check_result();
            stall = fast_phase ? 0 : $urandom_range(0, 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic test_measure_extremes();
      send_item(OP_MEASURE, 1'b1, {N_MEAS{16'h8000}});
      send_item(OP_MEASURE, 1'b1, {N_MEAS{16'h7FFF}});
      send_item(OP_MEASURE, 1'b1, '0);
      send_item(OP_MEASURE, 1'b0, any_sample());
      drain_results();
      write_csr(CSR_ACCEL_FS, 16'd3);
      write_csr(CSR_GYRO_FS, 16'd3);
      send_item(OP_MEASURE, 1'b1, {N_MEAS{16'h8000}});
      send_item(OP_MEASURE, 1'b1, {N_MEAS{16'h7FFF}});
   endtask

   task automatic test_idle_ops();
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
      send_item(OP_CAL_RESET, 1'b1, any_sample());
   endtask

   task automatic test_zero_length();
      drain_results();
      write_csr(CSR_CAL_N, 16'd0);
      send_item(OP_CAL_START, 1'b1, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
   endtask

   // one attempt: no valid sample fails, one valid sample completes
   task automatic test_single_attempt();
      drain_results();
      write_csr(CSR_CAL_N, 16'd1);
      send_item(OP_CAL_START, 1'b0, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b0, any_sample());
      send_item(OP_CAL_START, 1'b1, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b1, {N_MEAS{16'h7FFF}});
      send_item(OP_MEASURE, 1'b1, {N_MEAS{16'h8000}});
   endtask

   task automatic test_short_of_valid();
      drain_results();
      write_csr(CSR_CAL_N, 16'd4);
      send_item(OP_CAL_START, 1'b1, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
      repeat (3) send_item(OP_CAL_SAMPLE, 1'b0, any_sample());
   endtask

   // attempt count already at a lowered length finishes on the next sample
   task automatic test_length_lowered();
      drain_results();
      write_csr(CSR_ACCEL_FS, 16'd1);
      write_csr(CSR_GYRO_FS, 16'd2);
      write_csr(CSR_CAL_N, 16'hFFFF);
      send_item(OP_CAL_START, 1'b1, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
      drain_results();
      write_csr(CSR_CAL_N, 16'd2);
      send_item(OP_CAL_SAMPLE, 1'b1, any_sample());
      send_item(OP_MEASURE, 1'b1, any_sample());
      send_item(OP_CAL_RESET, 1'b0, any_sample());
   endtask

   task automatic test_random_traffic();
      int          kind;
      int          run_len;
      int          n_cal;
      int          ok_pct;
      int          pick;
      int unsigned cal_len;
      while (items_sent < ITEM_TARGET) begin
         drain_results();
         fast_phase = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1)) write_csr(CSR_ACCEL_FS, CSR_DATA_W'($urandom_range(0, 3)));
         if ($urandom_range(0, 1)) write_csr(CSR_GYRO_FS, CSR_DATA_W'($urandom_range(0, 3)));
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            pick = $urandom_range(0, 19);
            cal_len = (pick == 0) ? 0 : ((pick == 1) ? $urandom_range(25, 64)
                                                      : $urandom_range(1, 16));
            write_csr(CSR_CAL_N, CSR_DATA_W'(cal_len));
            for (int i = 0; i < N_MEAS; i++) axis_bias[i] = RAW_W'($urandom);
            noise_span = 1 << $urandom_range(0, 11);
            pick = $urandom_range(0, 3);
            ok_pct = (pick == 0) ? 100 : ((pick == 1) ? 95 : ((pick == 2) ? 75 : 40));
            send_item(OP_CAL_START, 1'($urandom_range(0, 1)), any_sample());
            n_cal = cal_len + $urandom_range(0, 2);
            for (int k = 0; k < n_cal; k++) begin
               if ($urandom_range(0, 99) < 12) send_item(OP_MEASURE, 1'b1, biased_sample());
               if ($urandom_range(0, 99) < 2) send_item(OP_CAL_RESET, 1'b1, any_sample());
               if ($urandom_range(0, 99) < 5) drain_results();
               send_item(OP_CAL_SAMPLE, $urandom_range(0, 99) < ok_pct,
                         ($urandom_range(0, 9) == 0) ? any_sample() : biased_sample());
            end
            run_len = $urandom_range(3, 12);
            repeat (run_len)
               send_item(OP_MEASURE, $urandom_range(0, 9) != 0,
                         ($urandom_range(0, 3) == 0) ? any_sample() : biased_sample());
         end else begin
            run_len = $urandom_range(8, 24);
            repeat (run_len)
               send_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), any_sample());
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      accel_fs_m = '0;
      gyro_fs_m  = '0;
      cal_len_m  = CAL_N_RESET;
      cal_running = 1'b0;
      clear_calibration();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_measure_extremes();
      test_idle_ops();
      test_zero_length();
      test_single_attempt();
      test_short_of_valid();
      test_length_lowered();
      test_random_traffic();
      drain_results();

      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
